// ===== rtl/core/sha1md_pkg.sv =====
// shared types, constants and round functions for the sha-1 digest block
package sha1md_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned NumWords   = 5;
  localparam int unsigned BlkW       = 512;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned RndW       = 7;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumWords-1:0][WordW-1:0] chain_t;

  localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam logic [3:0][WordW-1:0] K_TAB = {32'hCA62C1D6, 32'h8F1BBCDC,
                                             32'h6ED9EBA1, 32'h5A827999};

  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam logic [5:0] FILL_LEN      = 6'd56;
  localparam logic [5:0] FILL_LAST     = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR1,
    GRP_MAJ,
    GRP_PAR2
  } grp_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha1md_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1md_out_t;

  // control from the message sequencer to the compression unit
  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       start;
    logic       init;
  } sha1md_ctrl_t;

  function automatic grp_e round_grp(logic [RndW-1:0] rnd);
    grp_e g;
    priority if (rnd < RndW'(20)) g = GRP_CH;
    else if (rnd < RndW'(40))     g = GRP_PAR1;
    else if (rnd < RndW'(60))     g = GRP_MAJ;
    else                          g = GRP_PAR2;
    return g;
  endfunction

  function automatic word_t round_f(grp_e g, word_t b, word_t c, word_t d);
    word_t f;
    unique case (g)
      GRP_CH:  f = (b & c) | (~b & d);
      GRP_MAJ: f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/sha1md_compress.sv =====
// block window, message schedule and one-round-per-cycle compression unit
module sha1md_compress (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sha1md_pkg::sha1md_ctrl_t  ctrl_i,
  output logic                      busy_o,
  output sha1md_pkg::chain_t        chain_o
);
  import sha1md_pkg::*;

  logic [BlkW-1:0] blk_q, blk_d;
  word_t           a_q, b_q, c_q, d_q, e_q;
  word_t           a_d, b_d, c_d, d_d, e_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic            busy_q, busy_d;
  chain_t          chain_q, chain_d;

  word_t w0, w2, w8, w13, w_mix, w_new, t;
  grp_e  grp;

  always_comb begin
    // schedule taps: word k of the 16-word window sits at the top minus k words
    w0    = blk_q[BlkW-1 -: WordW];
    w2    = blk_q[BlkW-1-2*WordW -: WordW];
    w8    = blk_q[BlkW-1-8*WordW -: WordW];
    w13   = blk_q[BlkW-1-13*WordW -: WordW];
    w_mix = w13 ^ w8 ^ w2 ^ w0;
    w_new = {w_mix[WordW-2:0], w_mix[WordW-1]};
    grp   = round_grp(rnd_q);
    t     = {a_q[WordW-6:0], a_q[WordW-1 -: 5]} + round_f(grp, b_q, c_q, d_q)
            + e_q + K_TAB[grp] + w0;
  end

  always_comb begin
    blk_d   = blk_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    e_d     = e_q;
    rnd_d   = rnd_q;
    busy_d  = busy_q;
    chain_d = chain_q;
    if (ctrl_i.push) begin
      blk_d = {blk_q[BlkW-9:0], ctrl_i.push_byte};
    end
    if (ctrl_i.init) begin
      chain_d = H_INIT;
    end
    priority if (ctrl_i.start) begin
      a_d    = chain_q[0];
      b_d    = chain_q[1];
      c_d    = chain_q[2];
      d_d    = chain_q[3];
      e_d    = chain_q[4];
      rnd_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q && rnd_q == RndW'(Rounds)) begin
      // feed-forward into the chaining words
      chain_d[0] = chain_q[0] + a_q;
      chain_d[1] = chain_q[1] + b_q;
      chain_d[2] = chain_q[2] + c_q;
      chain_d[3] = chain_q[3] + d_q;
      chain_d[4] = chain_q[4] + e_q;
      busy_d     = 1'b0;
    end else if (busy_q) begin
      a_d   = t;
      b_d   = a_q;
      c_d   = {b_q[1:0], b_q[WordW-1:2]};
      d_d   = c_q;
      e_d   = d_q;
      blk_d = {blk_q[BlkW-WordW-1:0], w_new};
      rnd_d = rnd_q + RndW'(1);
    end else begin
      rnd_d = rnd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q   <= '0;
      busy_q  <= 1'b0;
      chain_q <= H_INIT;
    end else begin
      rnd_q   <= rnd_d;
      busy_q  <= busy_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

  assign busy_o  = busy_q;
  assign chain_o = chain_q;

endmodule

// ===== rtl/core/sha1_message_digest.sv =====
// sha-1 digest top level: byte intake, padding sequencer and digest output
// bytes are taken only while idle; each 64th byte stalls input for a compression
// (80 rounds, then feed-forward, on a single round unit)
// end of message: 9 to 72 padding bytes, one or two compressions, then 5 output words
// reset: async active low, chaining words to the initial hash, counts to zero
module sha1_message_digest (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  sha1md_pkg::sha1md_in_t   in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output sha1md_pkg::sha1md_out_t  out_data_o
);
  import sha1md_pkg::*;

  state_e       state_q, state_d;
  state_e       ret_q, ret_d;
  logic [5:0]   fill_q, fill_d;
  logic [60:0]  cnt_q, cnt_d;
  logic         first_q, first_d;
  logic         len_q, len_d;
  logic [2:0]   widx_q, widx_d;
  logic [63:0]  len_bits;
  logic [7:0]   len_byte;
  logic         in_acc, out_acc, wrap;
  logic         cmp_busy;
  sha1md_ctrl_t ctrl;
  chain_t       chain;

  sha1md_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .busy_o  (cmp_busy),
    .chain_o (chain)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign wrap        = (fill_q == FILL_LAST);
  assign len_bits    = {cnt_q, 3'b000};
  assign len_byte    = len_bits[{~fill_q[2:0], 3'b000} +: 8];

  always_comb begin
    out_data_o.digest_word = chain[widx_q];
    out_data_o.word_index  = widx_q;
    out_data_o.last_word   = (widx_q == LAST_WORD_IDX);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_data_i.has_byte && wrap) state_d = S_WAIT;
          else if (in_data_i.end_of_message)       state_d = S_PAD;
          else                                     state_d = S_IDLE;
        end
      end
      S_PAD: begin
        if (wrap) state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!cmp_busy) state_d = ret_q;
      end
      S_OUT: begin
        if (out_acc && widx_q == LAST_WORD_IDX) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ctrl    = '0;
    ret_d   = ret_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    len_d   = len_q;
    widx_d  = widx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.has_byte) begin
          ctrl.push      = 1'b1;
          ctrl.push_byte = in_data_i.msg_byte;
          ctrl.start     = wrap;
          fill_d         = fill_q + 6'd1;
          cnt_d          = cnt_q + 61'd1;
          ret_d          = in_data_i.end_of_message ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        ctrl.push  = 1'b1;
        ctrl.start = wrap;
        fill_d     = fill_q + 6'd1;
        priority if (first_q) begin
          ctrl.push_byte = PAD_BYTE;
          first_d        = 1'b0;
        end else if (len_q || fill_q == FILL_LEN) begin
          ctrl.push_byte = len_byte;
          len_d          = 1'b1;
        end else begin
          ctrl.push_byte = '0;
        end
        // the length always ends exactly on a block boundary
        ret_d = len_q ? S_OUT : S_PAD;
      end
      S_WAIT: begin
        ret_d = ret_q;
      end
      S_OUT: begin
        if (out_acc) begin
          if (widx_q == LAST_WORD_IDX) begin
            widx_d    = '0;
            ctrl.init = 1'b1;
            cnt_d     = '0;
            first_d   = 1'b1;
            len_d     = 1'b0;
          end else begin
            widx_d = widx_q + 3'd1;
          end
        end
      end
      default: ret_d = ret_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      first_q <= 1'b1;
      len_q   <= 1'b0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      len_q   <= len_d;
      widx_q  <= widx_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_out_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !cmp_busy)
    else $error("digest word shown while compression runs");

  a_start_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.start |-> (ctrl.push && fill_q == FILL_LAST))
    else $error("compression started without a full block");

  a_eom_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.end_of_message) |=> (state_q != S_IDLE))
    else $error("end of message did not start padding");

  a_last_word_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.last_word) |=> (state_q == S_IDLE && fill_q == '0 && cnt_q == '0))
    else $error("state not cleared after digest");
`endif

endmodule
